// ===== sv/hsirgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsirgb_pkg
// Shared types, widths and fixed-point constants of the HSI to RGB converter.
// ----------------------------------------------------------------------------
package hsirgb_pkg;

   // Port field widths.
   localparam int IN_W   = 16;
   localparam int CHAN_W = 17;

   // Internal datapath widths.
   localparam int HQW     = 48;   // hue widened to Q30 radians
   localparam int ZW      = 34;   // CORDIC angle accumulator
   localparam int XW      = 34;   // CORDIC x and y
   localparam int RATIO_W = 34;   // sector ratio r in Q30

   localparam int CORDIC_STEPS = 30;
   localparam int QUO_BITS     = 32;   // quotient bits of the tangent division

   // Angle constants in Q30 radians.
   localparam longint PI_Q30 = 64'sd3373259426;
   localparam longint P3_Q30 = PI_Q30 / 3;

   // Sector limits on the widened hue: 3*hq < N is the same as hq < ceil(N/3).
   localparam logic [HQW-1:0] SECTOR1_START = HQW'((2 * PI_Q30 + 2) / 3);
   localparam logic [HQW-1:0] SECTOR2_START = HQW'((4 * PI_Q30 + 2) / 3);
   localparam logic [HQW-1:0] HUE_LIMIT     = HQW'((6 * PI_Q30 + 2) / 3);

   // Offsets that turn hq into e = trunc((3*hq - (2k+1)*pi) / 3).
   // In the low and high sectors the rounding step depends on the sign of the
   // numerator, and the positive offset doubles as the threshold.
   localparam logic [HQW-1:0] OFFSET_LOW_POS  = HQW'(P3_Q30 + 1);
   localparam logic [HQW-1:0] OFFSET_LOW_NEG  = HQW'(P3_Q30);
   localparam logic [HQW-1:0] OFFSET_MID      = HQW'(3 * P3_Q30 + 2);
   localparam logic [HQW-1:0] OFFSET_HIGH_POS = HQW'(5 * P3_Q30 + 4);
   localparam logic [HQW-1:0] OFFSET_HIGH_NEG = HQW'(5 * P3_Q30 + 3);

   localparam logic signed [XW-1:0]      CORDIC_X0      = 34'sd1073741824;
   localparam longint                    SQRT3_HALF_Q30 = 64'sd929887698;
   localparam logic signed [RATIO_W-1:0] HALF_Q30       = 34'sd536870912;
   localparam longint                    CHAN_FIELD_MAX = 64'sd131071;

   typedef enum logic [1:0] {
      SECTOR_LOW  = 2'd0,
      SECTOR_MID  = 2'd1,
      SECTOR_HIGH = 2'd2
   } sector_type;

   // Per-pixel data that rides along the angle and ratio pipelines.
   typedef struct packed {
      logic [IN_W-1:0] saturation;
      logic [IN_W-1:0] intensity;
      sector_type      sector;
      logic            in_range;
      logic            frame_end;
   } side_type;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
      logic              hue_in_range;
      logic              frame_end;
   } result_type;

   // Arctangent of 2^-step in Q30 radians.
   function automatic logic [31:0] atan_q30(input int unsigned step);
      logic [31:0] value;
      case (step)
         0:       value = 32'h3243_F6A8;
         1:       value = 32'h1DAC_6705;
         2:       value = 32'h0FAD_BAFC;
         3:       value = 32'h07F5_6EA6;
         4:       value = 32'h03FE_AB76;
         5:       value = 32'h01FF_D55B;
         6:       value = 32'h00FF_FAAA;
         7:       value = 32'h007F_FF55;
         8:       value = 32'h003F_FFEA;
         9:       value = 32'h001F_FFFD;
         10:      value = 32'h000F_FFFF;
         11:      value = 32'h0007_FFFF;
         12:      value = 32'h0003_FFFF;
         13:      value = 32'h0001_FFFF;
         14:      value = 32'h0000_FFFF;
         15:      value = 32'h0000_7FFF;
         16:      value = 32'h0000_3FFF;
         17:      value = 32'h0000_1FFF;
         18:      value = 32'h0000_0FFF;
         19:      value = 32'h0000_07FF;
         20:      value = 32'h0000_03FF;
         21:      value = 32'h0000_01FF;
         22:      value = 32'h0000_00FF;
         23:      value = 32'h0000_007F;
         24:      value = 32'h0000_003F;
         25:      value = 32'h0000_001F;
         26:      value = 32'h0000_000F;
         27:      value = 32'h0000_0008;
         28:      value = 32'h0000_0004;
         29:      value = 32'h0000_0002;
         default: value = 32'h0000_0000;
      endcase
      return value;
   endfunction

endpackage

// ===== sv/hsirgb_sector.sv =====
// ----------------------------------------------------------------------------
// hsirgb_sector
// Input register, sector decision and sector-relative angle in Q30 radians.
// ----------------------------------------------------------------------------
module hsirgb_sector #(
   parameter int HUE_FRAC_BITS = 13
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                in_valid,
   input  logic [hsirgb_pkg::IN_W-1:0]         in_hue,
   input  logic [hsirgb_pkg::IN_W-1:0]         in_saturation,
   input  logic [hsirgb_pkg::IN_W-1:0]         in_intensity,
   input  logic                                in_end_of_frame,
   output logic                                out_valid,
   output hsirgb_pkg::side_type                out_side,
   output logic signed [hsirgb_pkg::ZW-1:0]    out_angle
);

   localparam int HQW       = hsirgb_pkg::HQW;
   localparam int ZW        = hsirgb_pkg::ZW;
   localparam int IN_W      = hsirgb_pkg::IN_W;
   localparam int HUE_SHIFT = 30 - HUE_FRAC_BITS;

   logic                 s0_valid_ff;
   logic [IN_W-1:0]      s0_hue_ff;
   logic [IN_W-1:0]      s0_saturation_ff;
   logic [IN_W-1:0]      s0_intensity_ff;
   logic                 s0_eof_ff;

   logic [HQW-1:0]       hq;
   logic [HQW-1:0]       offset;
   logic [HQW-1:0]       diff;
   hsirgb_pkg::side_type side_in;
   logic signed [ZW-1:0] angle_in;

   logic                 s1_valid_ff;
   hsirgb_pkg::side_type s1_side_ff;
   logic signed [ZW-1:0] s1_angle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= in_valid;
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_hue_ff        <= in_hue;
         s0_saturation_ff <= in_saturation;
         s0_intensity_ff  <= in_intensity;
         s0_eof_ff        <= in_end_of_frame;
         s1_side_ff       <= side_in;
         s1_angle_ff      <= angle_in;
      end
   end

   always_comb begin
      hq = HQW'(s0_hue_ff) << HUE_SHIFT;

      side_in.saturation = s0_saturation_ff;
      side_in.intensity  = s0_intensity_ff;
      side_in.frame_end  = s0_eof_ff;
      side_in.in_range   = (hq < hsirgb_pkg::HUE_LIMIT);
      if (hq < hsirgb_pkg::SECTOR1_START) begin
         side_in.sector = hsirgb_pkg::SECTOR_LOW;
      end else if (hq < hsirgb_pkg::SECTOR2_START) begin
         side_in.sector = hsirgb_pkg::SECTOR_MID;
      end else begin
         side_in.sector = hsirgb_pkg::SECTOR_HIGH;
      end

      case (side_in.sector)
         hsirgb_pkg::SECTOR_LOW: begin
            offset = (hq >= hsirgb_pkg::OFFSET_LOW_POS) ? hsirgb_pkg::OFFSET_LOW_POS
                                                        : hsirgb_pkg::OFFSET_LOW_NEG;
         end
         hsirgb_pkg::SECTOR_MID: begin
            offset = hsirgb_pkg::OFFSET_MID;
         end
         hsirgb_pkg::SECTOR_HIGH: begin
            offset = (hq >= hsirgb_pkg::OFFSET_HIGH_POS) ? hsirgb_pkg::OFFSET_HIGH_POS
                                                         : hsirgb_pkg::OFFSET_HIGH_NEG;
         end
         default: begin
            offset = '0;
         end
      endcase

      // In range the offset angle lies within plus or minus pi/3. An out of
      // range hue is sent through with a zero angle; its channels are zeroed.
      diff     = hq - offset;
      angle_in = side_in.in_range ? $signed(diff[ZW-1:0]) : '0;
   end

   assign out_valid = s1_valid_ff;
   assign out_side  = s1_side_ff;
   assign out_angle = s1_angle_ff;

endmodule

// ===== sv/hsirgb_cordic.sv =====
// ----------------------------------------------------------------------------
// hsirgb_cordic
// Rotation-mode CORDIC, one micro-rotation per pipeline stage.
// ----------------------------------------------------------------------------
module hsirgb_cordic (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic                             in_valid,
   input  hsirgb_pkg::side_type             in_side,
   input  logic signed [hsirgb_pkg::ZW-1:0] in_angle,
   output logic                             out_valid,
   output hsirgb_pkg::side_type             out_side,
   output logic signed [hsirgb_pkg::XW-1:0] out_x,
   output logic signed [hsirgb_pkg::XW-1:0] out_y
);

   localparam int ZW    = hsirgb_pkg::ZW;
   localparam int XW    = hsirgb_pkg::XW;
   localparam int STEPS = hsirgb_pkg::CORDIC_STEPS;

   // Stage inputs: index 0 is the start vector, index g+1 is register g.
   logic signed [XW-1:0] x_stage     [STEPS+1];
   logic signed [XW-1:0] y_stage     [STEPS+1];
   logic signed [ZW-1:0] z_stage     [STEPS];
   logic                 valid_stage [STEPS+1];
   hsirgb_pkg::side_type side_stage  [STEPS+1];

   logic signed [XW-1:0] x_ff     [STEPS];
   logic signed [XW-1:0] y_ff     [STEPS];
   logic signed [ZW-1:0] z_ff     [STEPS-1];
   logic                 valid_ff [STEPS];
   hsirgb_pkg::side_type side_ff  [STEPS];

   assign x_stage[0]     = hsirgb_pkg::CORDIC_X0;
   assign y_stage[0]     = '0;
   assign z_stage[0]     = in_angle;
   assign valid_stage[0] = in_valid;
   assign side_stage[0]  = in_side;

   for (genvar g = 0; g < STEPS; g++) begin : g_step
      localparam logic signed [ZW-1:0] ATAN_STEP = ZW'(hsirgb_pkg::atan_q30(g));

      logic signed [XW-1:0] dx;
      logic signed [XW-1:0] dy;
      logic signed [XW-1:0] x_in;
      logic signed [XW-1:0] y_in;
      logic                 rotate_down;

      always_comb begin
         dx          = y_stage[g] >>> g;
         dy          = x_stage[g] >>> g;
         rotate_down = z_stage[g][ZW-1];
         x_in        = rotate_down ? (x_stage[g] + dx) : (x_stage[g] - dx);
         y_in        = rotate_down ? (y_stage[g] - dy) : (y_stage[g] + dy);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (advance) begin
            valid_ff[g] <= valid_stage[g];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[g]    <= x_in;
            y_ff[g]    <= y_in;
            side_ff[g] <= side_stage[g];
         end
      end

      // The last rotation has no use for the residual angle.
      if (g < STEPS - 1) begin : g_angle
         logic signed [ZW-1:0] z_in;

         assign z_in = rotate_down ? (z_stage[g] + ATAN_STEP) : (z_stage[g] - ATAN_STEP);

         always_ff @(posedge clock) begin
            if (advance) begin
               z_ff[g] <= z_in;
            end
         end

         assign z_stage[g+1] = z_ff[g];
      end

      assign x_stage[g+1]     = x_ff[g];
      assign y_stage[g+1]     = y_ff[g];
      assign valid_stage[g+1] = valid_ff[g];
      assign side_stage[g+1]  = side_ff[g];
   end

   assign out_valid = valid_stage[STEPS];
   assign out_side  = side_stage[STEPS];
   assign out_x     = x_stage[STEPS];
   assign out_y     = y_stage[STEPS];

endmodule

// ===== sv/hsirgb_ratio.sv =====
// ----------------------------------------------------------------------------
// hsirgb_ratio
// Sector ratio r = 1/2 - (sqrt3/2) * y / x, with a pipelined restoring divider.
// ----------------------------------------------------------------------------
module hsirgb_ratio (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic                                  in_valid,
   input  hsirgb_pkg::side_type                  in_side,
   input  logic signed [hsirgb_pkg::XW-1:0]      in_x,
   input  logic signed [hsirgb_pkg::XW-1:0]      in_y,
   output logic                                  out_valid,
   output hsirgb_pkg::side_type                  out_side,
   output logic signed [hsirgb_pkg::RATIO_W-1:0] out_ratio
);

   localparam int XW      = hsirgb_pkg::XW;
   localparam int QB      = hsirgb_pkg::QUO_BITS;
   localparam int RW      = XW - 1;          // divisor and partial remainder
   localparam int PW      = RW + QB;         // product and dividend
   localparam int RATIO_W = hsirgb_pkg::RATIO_W;

   localparam logic signed [PW-1:0] SQRT3_HALF = PW'(hsirgb_pkg::SQRT3_HALF_Q30);

   // Product stage.
   logic signed [PW-1:0] prod;
   logic [PW-1:0]        mag;
   logic [RW-1:0]        divisor_in;

   logic                 d0_valid_ff;
   hsirgb_pkg::side_type d0_side_ff;
   logic                 d0_neg_ff;
   logic [RW-1:0]        d0_rem_ff;
   logic [QB-1:0]        d0_lq_ff;
   logic [RW-1:0]        d0_div_ff;

   always_comb begin
      prod       = SQRT3_HALF * PW'(in_y);
      mag        = prod[PW-1] ? PW'(-prod) : PW'(prod);
      divisor_in = (in_x[XW-1] || (in_x == '0)) ? RW'(1) : in_x[RW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d0_valid_ff <= 1'b0;
      end else if (advance) begin
         d0_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d0_side_ff <= in_side;
         d0_neg_ff  <= prod[PW-1];
         d0_rem_ff  <= mag[PW-1:QB];
         d0_lq_ff   <= mag[QB-1:0];
         d0_div_ff  <= divisor_in;
      end
   end

   // Division stages. The low dividend bits shift out of the top of lq while
   // the quotient bits shift in at the bottom.
   logic [RW-1:0]        rem_stage   [QB];
   logic [RW-1:0]        div_stage   [QB];
   logic [QB-1:0]        lq_stage    [QB+1];
   logic                 neg_stage   [QB+1];
   logic                 valid_stage [QB+1];
   hsirgb_pkg::side_type side_stage  [QB+1];

   logic [RW-1:0]        rem_ff   [QB-1];
   logic [RW-1:0]        div_ff   [QB-1];
   logic [QB-1:0]        lq_ff    [QB];
   logic                 neg_ff   [QB];
   logic                 valid_ff [QB];
   hsirgb_pkg::side_type side_ff  [QB];

   assign rem_stage[0]   = d0_rem_ff;
   assign div_stage[0]   = d0_div_ff;
   assign lq_stage[0]    = d0_lq_ff;
   assign neg_stage[0]   = d0_neg_ff;
   assign valid_stage[0] = d0_valid_ff;
   assign side_stage[0]  = d0_side_ff;

   for (genvar j = 0; j < QB; j++) begin : g_div
      logic [RW:0]   trial;
      logic [RW:0]   reduced;
      logic          fits;
      logic [QB-1:0] lq_in;

      always_comb begin
         trial   = {rem_stage[j], lq_stage[j][QB-1]};
         reduced = trial - {1'b0, div_stage[j]};
         fits    = (trial >= {1'b0, div_stage[j]});
         lq_in   = {lq_stage[j][QB-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (advance) begin
            valid_ff[j] <= valid_stage[j];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            lq_ff[j]   <= lq_in;
            neg_ff[j]  <= neg_stage[j];
            side_ff[j] <= side_stage[j];
         end
      end

      // The final step needs neither the remainder nor the divisor.
      if (j < QB - 1) begin : g_carry
         logic [RW-1:0] rem_in;

         assign rem_in = fits ? reduced[RW-1:0] : trial[RW-1:0];

         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[j] <= rem_in;
               div_ff[j] <= div_stage[j];
            end
         end

         assign rem_stage[j+1] = rem_ff[j];
         assign div_stage[j+1] = div_ff[j];
      end

      assign lq_stage[j+1]    = lq_ff[j];
      assign neg_stage[j+1]   = neg_ff[j];
      assign valid_stage[j+1] = valid_ff[j];
      assign side_stage[j+1]  = side_ff[j];
   end

   // Ratio stage: the quotient takes the sign of y, rounding toward zero.
   logic signed [RATIO_W-1:0] quo_signed;
   logic signed [RATIO_W-1:0] ratio_in;

   logic                      r_valid_ff;
   hsirgb_pkg::side_type      r_side_ff;
   logic signed [RATIO_W-1:0] r_ratio_ff;

   always_comb begin
      quo_signed = $signed(RATIO_W'(lq_stage[QB]));
      if (neg_stage[QB]) begin
         quo_signed = -quo_signed;
      end
      ratio_in = hsirgb_pkg::HALF_Q30 - quo_signed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
      end else if (advance) begin
         r_valid_ff <= valid_stage[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r_side_ff  <= side_stage[QB];
         r_ratio_ff <= ratio_in;
      end
   end

   assign out_valid = r_valid_ff;
   assign out_side  = r_side_ff;
   assign out_ratio = r_ratio_ff;

endmodule

// ===== sv/hsirgb_mix.sv =====
// ----------------------------------------------------------------------------
// hsirgb_mix
// Channel arithmetic, saturation and sector routing to blue, green and red.
// ----------------------------------------------------------------------------
module hsirgb_mix #(
   parameter int CHAN_FRAC_BITS = 15
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic                                  in_valid,
   input  hsirgb_pkg::side_type                  in_side,
   input  logic signed [hsirgb_pkg::RATIO_W-1:0] in_ratio,
   output logic                                  out_valid,
   output hsirgb_pkg::result_type                out_result
);

   localparam int CHAN_W  = hsirgb_pkg::CHAN_W;
   localparam int IN_W    = hsirgb_pkg::IN_W;
   localparam int RATIO_W = hsirgb_pkg::RATIO_W;
   localparam int EW      = IN_W + 1;                   // input as signed
   localparam int SRPW    = EW + RATIO_W;               // S*r product
   localparam int SRW     = SRPW - 30;                  // S*r in channel units
   localparam int ASW     = ((CHAN_FRAC_BITS > IN_W) ? CHAN_FRAC_BITS : IN_W) + 2;
   localparam int BSW     = ((CHAN_FRAC_BITS + 2) > (SRW + 1)) ? (CHAN_FRAC_BITS + 2)
                                                               : (SRW + 1);
   localparam int APW     = EW + ASW;
   localparam int BPW     = EW + BSW;
   localparam int VW      = EW + ((ASW > BSW) ? ASW : BSW) + 2;

   localparam longint TOP_FULL = longint'(3) << CHAN_FRAC_BITS;
   localparam longint TOP_LIM  = (TOP_FULL > hsirgb_pkg::CHAN_FIELD_MAX) ?
                                 hsirgb_pkg::CHAN_FIELD_MAX : TOP_FULL;

   localparam logic signed [ASW-1:0] ONE_A    = ASW'(longint'(1) << CHAN_FRAC_BITS);
   localparam logic signed [BSW-1:0] ONE_B    = BSW'(longint'(1) << CHAN_FRAC_BITS);
   localparam logic signed [VW-1:0]  CHAN_TOP = VW'(TOP_LIM);

   function automatic logic [CHAN_W-1:0] clamp_channel(input logic signed [VW-1:0] v);
      logic [CHAN_W-1:0] result;
      if (v < 0) begin
         result = '0;
      end else if (v > CHAN_TOP) begin
         result = CHAN_TOP[CHAN_W-1:0];
      end else begin
         result = v[CHAN_W-1:0];
      end
      return result;
   endfunction

   // Stage 1: S*r and I*(1-S).
   logic signed [EW-1:0]   m1_i;
   logic signed [EW-1:0]   m1_s;
   logic signed [ASW-1:0]  a_diff;
   logic signed [SRPW-1:0] sr_prod_in;
   logic signed [APW-1:0]  a_prod_in;

   logic                   m1_valid_ff;
   hsirgb_pkg::side_type   m1_side_ff;
   logic signed [SRPW-1:0] m1_sr_prod_ff;
   logic signed [APW-1:0]  m1_a_prod_ff;

   always_comb begin
      m1_i       = $signed({1'b0, in_side.intensity});
      m1_s       = $signed({1'b0, in_side.saturation});
      a_diff     = ONE_A - $signed(ASW'(in_side.saturation));
      sr_prod_in = SRPW'(m1_s) * SRPW'(in_ratio);
      a_prod_in  = APW'(m1_i) * APW'(a_diff);
   end

   // Stage 2: I*(1 + floor(S*r)).
   logic signed [EW-1:0]  m2_i;
   logic signed [SRW-1:0] sr;
   logic signed [BSW-1:0] b_fac;
   logic signed [BPW-1:0] b_prod_in;

   logic                  m2_valid_ff;
   hsirgb_pkg::side_type  m2_side_ff;
   logic signed [APW-1:0] m2_a_prod_ff;
   logic signed [BPW-1:0] m2_b_prod_ff;

   always_comb begin
      m2_i      = $signed({1'b0, m1_side_ff.intensity});
      sr        = $signed(m1_sr_prod_ff[SRPW-1:30]);
      b_fac     = ONE_B + BSW'(sr);
      b_prod_in = BPW'(m2_i) * BPW'(b_fac);
   end

   // Stage 3: a, b and c = 3I - (a + b), all before saturation.
   logic signed [EW-1:0] m3_i;
   logic signed [VW-1:0] i3;
   logic signed [VW-1:0] a_in;
   logic signed [VW-1:0] b_in;
   logic signed [VW-1:0] c_in;

   logic                 m3_valid_ff;
   hsirgb_pkg::side_type m3_side_ff;
   logic signed [VW-1:0] m3_a_ff;
   logic signed [VW-1:0] m3_b_ff;
   logic signed [VW-1:0] m3_c_ff;

   always_comb begin
      m3_i = $signed({1'b0, m2_side_ff.intensity});
      i3   = VW'(m3_i) + (VW'(m3_i) <<< 1);
      a_in = VW'(m2_a_prod_ff >>> CHAN_FRAC_BITS);
      b_in = VW'(m2_b_prod_ff >>> CHAN_FRAC_BITS);
      c_in = i3 - (a_in + b_in);
   end

   // Stage 4: saturate and route by sector.
   logic [CHAN_W-1:0]      a_sat;
   logic [CHAN_W-1:0]      b_sat;
   logic [CHAN_W-1:0]      c_sat;
   hsirgb_pkg::result_type result_in;

   logic                   m4_valid_ff;
   hsirgb_pkg::result_type m4_result_ff;

   always_comb begin
      a_sat = clamp_channel(m3_a_ff);
      b_sat = clamp_channel(m3_b_ff);
      c_sat = clamp_channel(m3_c_ff);

      result_in.hue_in_range = m3_side_ff.in_range;
      result_in.frame_end    = m3_side_ff.frame_end;
      case (m3_side_ff.sector)
         hsirgb_pkg::SECTOR_LOW: begin
            result_in.blue  = a_sat;
            result_in.red   = b_sat;
            result_in.green = c_sat;
         end
         hsirgb_pkg::SECTOR_MID: begin
            result_in.red   = a_sat;
            result_in.green = b_sat;
            result_in.blue  = c_sat;
         end
         hsirgb_pkg::SECTOR_HIGH: begin
            result_in.green = a_sat;
            result_in.blue  = b_sat;
            result_in.red   = c_sat;
         end
         default: begin
            result_in.blue  = '0;
            result_in.green = '0;
            result_in.red   = '0;
         end
      endcase

      if (!m3_side_ff.in_range) begin
         result_in.blue  = '0;
         result_in.green = '0;
         result_in.red   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
         m3_valid_ff <= 1'b0;
         m4_valid_ff <= 1'b0;
      end else if (advance) begin
         m1_valid_ff <= in_valid;
         m2_valid_ff <= m1_valid_ff;
         m3_valid_ff <= m2_valid_ff;
         m4_valid_ff <= m3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m1_side_ff    <= in_side;
         m1_sr_prod_ff <= sr_prod_in;
         m1_a_prod_ff  <= a_prod_in;
         m2_side_ff    <= m1_side_ff;
         m2_a_prod_ff  <= m1_a_prod_ff;
         m2_b_prod_ff  <= b_prod_in;
         m3_side_ff    <= m2_side_ff;
         m3_a_ff       <= a_in;
         m3_b_ff       <= b_in;
         m3_c_ff       <= c_in;
         m4_result_ff  <= result_in;
      end
   end

   assign out_valid  = m4_valid_ff;
   assign out_result = m4_result_ff;

endmodule

// ===== sv/hsi_to_rgb_pixel_top.sv =====
// ----------------------------------------------------------------------------
// hsi_to_rgb_pixel_top
// HSI to RGB pixel converter using the three-sector rule, fully pipelined.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake               Payload
//   req_      in          req_valid / req_ready   hue, saturation, intensity,
//                                                 end_of_frame
//   rsp_      out         rsp_valid / rsp_ready   blue, green, red,
//                                                 hue_in_range, frame_end
//
// One transaction is accepted per clock while req_ready is high. A result
// passes two sector stages, 30 CORDIC stages, 34 stages for the tangent
// product and the one-bit-per-stage divider, four channel stages and the
// output register before it appears on rsp_. Reset is synchronous and
// clears only the valid bits. When the output register and the skid
// register both hold results, the whole pipeline freezes in place and
// req_ready drops; req_ready comes straight from a flip-flop.
//
module hsi_to_rgb_pixel_top #(
   parameter int CHAN_FRAC_BITS = 15,
   parameter int HUE_FRAC_BITS  = 13
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_hue,
   input  logic [15:0] req_saturation,
   input  logic [15:0] req_intensity,
   input  logic        req_end_of_frame,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [16:0] rsp_blue,
   output logic [16:0] rsp_green,
   output logic [16:0] rsp_red,
   output logic        rsp_hue_in_range,
   output logic        rsp_frame_end
);

   // Every pipeline stage moves together while the skid register is empty.
   // A stage that holds a bubble simply carries a cleared valid bit.
   logic advance;

   logic                                    sec_valid;
   hsirgb_pkg::side_type                    sec_side;
   logic signed [hsirgb_pkg::ZW-1:0]        sec_angle;

   logic                                    cor_valid;
   hsirgb_pkg::side_type                    cor_side;
   logic signed [hsirgb_pkg::XW-1:0]        cor_x;
   logic signed [hsirgb_pkg::XW-1:0]        cor_y;

   logic                                    rat_valid;
   hsirgb_pkg::side_type                    rat_side;
   logic signed [hsirgb_pkg::RATIO_W-1:0]   rat_ratio;

   logic                                    mix_valid;
   hsirgb_pkg::result_type                  mix_result;

   hsirgb_sector #(
      .HUE_FRAC_BITS(HUE_FRAC_BITS)
   ) u_sector (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .in_valid        (req_valid),
      .in_hue          (req_hue),
      .in_saturation   (req_saturation),
      .in_intensity    (req_intensity),
      .in_end_of_frame (req_end_of_frame),
      .out_valid       (sec_valid),
      .out_side        (sec_side),
      .out_angle       (sec_angle)
   );

   hsirgb_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sec_valid),
      .in_side   (sec_side),
      .in_angle  (sec_angle),
      .out_valid (cor_valid),
      .out_side  (cor_side),
      .out_x     (cor_x),
      .out_y     (cor_y)
   );

   hsirgb_ratio u_ratio (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (cor_valid),
      .in_side   (cor_side),
      .in_x      (cor_x),
      .in_y      (cor_y),
      .out_valid (rat_valid),
      .out_side  (rat_side),
      .out_ratio (rat_ratio)
   );

   hsirgb_mix #(
      .CHAN_FRAC_BITS(CHAN_FRAC_BITS)
   ) u_mix (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (rat_valid),
      .in_side    (rat_side),
      .in_ratio   (rat_ratio),
      .out_valid  (mix_valid),
      .out_result (mix_result)
   );

   // Output register with a skid register behind it. The pipeline runs
   // whenever the skid register is empty, so a result leaving the last stage
   // always has a place to land even if rsp_ready is low in that cycle.
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   hsirgb_pkg::result_type rsp_data_ff;
   hsirgb_pkg::result_type rsp_data_in;
   logic                   skid_valid_ff;
   logic                   skid_valid_in;
   hsirgb_pkg::result_type skid_data_ff;
   hsirgb_pkg::result_type skid_data_in;
   logic                   push;
   logic                   out_free;

   assign advance  = !skid_valid_ff;
   assign push     = advance && mix_valid;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         // The skid register, when full, is older than anything in flight.
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = push;
            rsp_data_in  = mix_result;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = mix_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign req_ready        = advance;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_blue         = rsp_data_ff.blue;
   assign rsp_green        = rsp_data_ff.green;
   assign rsp_red          = rsp_data_ff.red;
   assign rsp_hue_in_range = rsp_data_ff.hue_in_range;
   assign rsp_frame_end    = rsp_data_ff.frame_end;

endmodule
